>>> hw/rtl/rghpc_pkg.sv
`default_nettype none

package rghpc_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned GAIN_W    = 12;
  localparam int unsigned CC_W      = 3;
  localparam int unsigned PROD_W    = PIX_W + GAIN_W;
  localparam int unsigned NUM_W     = 2 * PIX_W;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DIV_STEPS = PIX_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;
  localparam logic [CC_W-1:0]   CC_RESET   = 3'd3;
  localparam logic [CC_W-1:0]   CC_MIN     = 3'd3;

  // 255.0 in Q12.8
  localparam logic [PROD_W-1:0] OVER_LIMIT = 20'd65280;

  // Word in flight through the quotient stages
  typedef struct packed {
    logic             eoi;
    logic             over;
    logic [PIX_W-1:0] r_dir;
    logic [PIX_W-1:0] g_dir;
    logic [PIX_W-1:0] b_dir;
    logic [PIX_W-1:0] m;
    logic [NUM_W-1:0] nr;
    logic [NUM_W-1:0] ng;
    logic [NUM_W-1:0] nb;
    logic [PIX_W-1:0] qr;
    logic [PIX_W-1:0] qg;
    logic [PIX_W-1:0] qb;
  } div_word_t;

endpackage

`default_nettype wire

>>> hw/rtl/rghpc_in_if.sv
`default_nettype none

interface rghpc_in_if import rghpc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic             end_of_image;

  modport source (output valid, red_in, green_in, blue_in, end_of_image, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, end_of_image, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rghpc_out_if.sv
`default_nettype none

interface rghpc_out_if import rghpc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic             end_of_image_out;

  modport source (output valid, red_out, green_out, blue_out, end_of_image_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, end_of_image_out, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rghpc_div_step.sv
`default_nettype none

// One restoring step of the quotient for all three channels.
module rghpc_div_step import rghpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic [STEP_W-1:0] bit_idx,
  input  wire logic              valid_in,
  input  wire div_word_t         word_in,
  output logic                   valid,
  output div_word_t              word
);

  div_word_t        word_next;
  logic [NUM_W-1:0] dsh;
  logic [PIX_W-1:0] qbit;

  always_comb begin
    dsh       = NUM_W'(word_in.m) << bit_idx;
    qbit      = PIX_W'(1) << bit_idx;
    word_next = word_in;
    if (word_in.nr >= dsh) begin
      word_next.nr = word_in.nr - dsh;
      word_next.qr = word_in.qr | qbit;
    end
    if (word_in.ng >= dsh) begin
      word_next.ng = word_in.ng - dsh;
      word_next.qg = word_in.qg | qbit;
    end
    if (word_in.nb >= dsh) begin
      word_next.nb = word_in.nb - dsh;
      word_next.qb = word_in.qb | qbit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  // advance the payload; no reset needed
  always_ff @(posedge clk) begin
    if (advance) begin
      word <= word_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rgb_gain_hue_preserving_clamp.sv
// Each accepted input word passes stage 1, stage 2, the quotient stages and the output register.
// Throughput: one pixel per clock; a new word may enter every cycle unless the output stalls.
// The depth is set by the eight quotient stages, one bit per stage.
// A stall at the output holds every stage; nothing is lost or repeated.
// Reset (rst, synchronous, active high) empties the pipeline and loads
// gain = 1.0 (256) and channel_count = 3.
`default_nettype none

module rgb_gain_hue_preserving_clamp import rghpc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  rghpc_in_if.sink                  pix_in,
  rghpc_out_if.source               pix_out
);

  // Configuration registers
  logic [GAIN_W-1:0] gain;
  logic [CC_W-1:0]   channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain          <= GAIN_RESET;
      channel_count <= CC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN:          gain          <= cfg_data[GAIN_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CC_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; the output register frees as it drains.
  logic advance;
  logic out_valid;

  assign advance      = !out_valid || pix_out.ready;
  assign pix_in.ready = advance;

  // Stage 1: products and the largest channel byte
  logic              v1;
  logic              eoi1;
  logic              pass1;
  logic [PIX_W-1:0]  r1, g1, b1, m1;
  logic [PROD_W-1:0] pr1, pg1, pb1;
  logic [PIX_W-1:0]  m_next;

  always_comb begin
    m_next = pix_in.red_in;
    if (pix_in.green_in > m_next) m_next = pix_in.green_in;
    if (pix_in.blue_in > m_next)  m_next = pix_in.blue_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      eoi1  <= pix_in.end_of_image;
      pass1 <= (channel_count < CC_MIN);
      r1    <= pix_in.red_in;
      g1    <= pix_in.green_in;
      b1    <= pix_in.blue_in;
      m1    <= m_next;
      pr1   <= PROD_W'(pix_in.red_in)   * PROD_W'(gain);
      pg1   <= PROD_W'(pix_in.green_in) * PROD_W'(gain);
      pb1   <= PROD_W'(pix_in.blue_in)  * PROD_W'(gain);
    end
  end

  // Stage 2: overflow test, plain results and dividends.
  // The gain cancels in product * 255 / max_product, so the quotient is
  // floor(byte * 255 / max_byte) on 8-bit values.
  logic      v2;
  div_word_t w2;
  div_word_t w2_next;
  logic      over_next;

  always_comb begin
    over_next     = !pass1 && ((pr1 > OVER_LIMIT) || (pg1 > OVER_LIMIT) ||
                               (pb1 > OVER_LIMIT));
    w2_next       = '0;
    w2_next.eoi   = eoi1;
    w2_next.over  = over_next;
    w2_next.m     = m1;
    w2_next.r_dir = pass1 ? r1 : pr1[NUM_W-1:PIX_W];
    w2_next.g_dir = pass1 ? g1 : pg1[NUM_W-1:PIX_W];
    w2_next.b_dir = pass1 ? b1 : pb1[NUM_W-1:PIX_W];
    // byte * 255 as (byte << 8) - byte
    w2_next.nr    = {r1, {PIX_W{1'b0}}} - NUM_W'(r1);
    w2_next.ng    = {g1, {PIX_W{1'b0}}} - NUM_W'(g1);
    w2_next.nb    = {b1, {PIX_W{1'b0}}} - NUM_W'(b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      w2 <= w2_next;
    end
  end

  // Stages 3 to 10: one quotient bit each, most significant first
  logic      dv [DIV_STEPS+1];
  div_word_t dw [DIV_STEPS+1];

  assign dv[0] = v2;
  assign dw[0] = w2;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rghpc_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .bit_idx  (STEP_W'(DIV_STEPS - 1 - i)),
      .valid_in (dv[i]),
      .word_in  (dw[i]),
      .valid    (dv[i+1]),
      .word     (dw[i+1])
    );
  end

  // Stage 11: output register, pick the rescaled or the plain result
  logic             eoi_o;
  logic [PIX_W-1:0] r_o, g_o, b_o;
  div_word_t        wl;

  assign wl = dw[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      eoi_o <= wl.eoi;
      r_o   <= wl.over ? wl.qr : wl.r_dir;
      g_o   <= wl.over ? wl.qg : wl.g_dir;
      b_o   <= wl.over ? wl.qb : wl.b_dir;
    end
  end

  assign pix_out.valid            = out_valid;
  assign pix_out.red_out          = r_o;
  assign pix_out.green_out        = g_o;
  assign pix_out.blue_out         = b_o;
  assign pix_out.end_of_image_out = eoi_o;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid after reset");

  // A stalled word stays in the output register
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pix_out.ready |=> out_valid)
    else $error("stalled output word dropped");

  // The rescale path only starts with a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    v2 && w2.over |-> w2.m != '0)
    else $error("rescale with zero max channel");

  // After the last step every remainder is below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv[DIV_STEPS] && wl.over |->
      (wl.nr < NUM_W'(wl.m)) && (wl.ng < NUM_W'(wl.m)) && (wl.nb < NUM_W'(wl.m)))
    else $error("quotient remainder out of range");

endmodule

`default_nettype wire

>>> tb/sv/rghpc_checker.sv
`timescale 1ns / 100ps

module rghpc_checker import rghpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  rghpc_in_if                  pix_in,
  rghpc_out_if                 pix_out,
  output int unsigned          mismatches,
  output int unsigned          outstanding
);

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             eoi;
  } pixel_t;

  logic [GAIN_W-1:0] gain_q;
  logic [CC_W-1:0]   count_q;
  pixel_t            scaled_px[$];
  pixel_t            want;

  // Share of the peak product, mapped so the peak itself lands on 255
  function automatic logic [PIX_W-1:0] share_of_peak(input logic [PROD_W-1:0] part,
                                                     input logic [PROD_W-1:0] peak);
    logic [PROD_W+7:0] num;
    logic [PROD_W+7:0] quot;
    num  = (PROD_W + 8)'(part) * (PROD_W + 8)'(255);
    quot = num / (PROD_W + 8)'(peak);
    return (quot > 255) ? 8'd255 : quot[PIX_W-1:0];
  endfunction

  function automatic pixel_t apply_gain(input pixel_t px, input logic [GAIN_W-1:0] g,
                                        input logic [CC_W-1:0] cc);
    logic [PROD_W-1:0] pr;
    logic [PROD_W-1:0] pg;
    logic [PROD_W-1:0] pb;
    logic [PROD_W-1:0] peak;
    pixel_t            res;
    res = px;
    if (cc >= CC_MIN) begin
      pr   = PROD_W'(px.red) * PROD_W'(g);
      pg   = PROD_W'(px.green) * PROD_W'(g);
      pb   = PROD_W'(px.blue) * PROD_W'(g);
      peak = pr;
      if (pg > peak) peak = pg;
      if (pb > peak) peak = pb;
      if (peak > OVER_LIMIT) begin
        res.red   = share_of_peak(pr, peak);
        res.green = share_of_peak(pg, peak);
        res.blue  = share_of_peak(pb, peak);
      end else begin
        res.red   = pr[15:8];
        res.green = pg[15:8];
        res.blue  = pb[15:8];
      end
    end
    return res;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      gain_q  = GAIN_RESET;
      count_q = CC_RESET;
      scaled_px.delete();
      outstanding = 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        scaled_px.push_back(apply_gain({pix_in.red_in, pix_in.green_in, pix_in.blue_in,
                                        pix_in.end_of_image}, gain_q, count_q));
      end
      if (pix_out.valid && pix_out.ready) begin
        if (scaled_px.size() == 0) begin
          $error("output word with no pixel pending");
          mismatches++;
        end else begin
          want = scaled_px.pop_front();
          if (pix_out.red_out !== want.red) begin
            $error("red_out: expected %0d, got %0d", want.red, pix_out.red_out);
            mismatches++;
          end
          if (pix_out.green_out !== want.green) begin
            $error("green_out: expected %0d, got %0d", want.green, pix_out.green_out);
            mismatches++;
          end
          if (pix_out.blue_out !== want.blue) begin
            $error("blue_out: expected %0d, got %0d", want.blue, pix_out.blue_out);
            mismatches++;
          end
          if (pix_out.end_of_image_out !== want.eoi) begin
            $error("end_of_image_out: expected %0d, got %0d", want.eoi,
                   pix_out.end_of_image_out);
            mismatches++;
          end
        end
      end
      // New settings apply to words accepted after this edge
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN:          gain_q  = cfg_data[GAIN_W-1:0];
          REG_CHANNEL_COUNT: count_q = cfg_data[CC_W-1:0];
          default: ;
        endcase
      end
      outstanding = scaled_px.size();
    end
  end

endmodule

>>> tb/sv/tb_rgb_gain_hue_preserving_clamp.sv
`timescale 1ns / 100ps

module tb_rgb_gain_hue_preserving_clamp;
  import rghpc_pkg::*;

  // Pipeline depth of the block; settle() adds a margin to it
  localparam int LATENCY     = 11;
  // Cycles with no word moving on either side before the run is abandoned
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 13;
  localparam int PHASE_WORDS = 100;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rghpc_in_if  pix_in ();
  rghpc_out_if pix_out ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned stall_cycles = 0;

  // Idle insertion on both sides; cleared for one long back-to-back stretch
  bit                gaps_on = 1'b1;
  logic [GAIN_W-1:0] cur_gain = GAIN_RESET;
  int                phase;
  int                n;

  rgb_gain_hue_preserving_clamp dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .pix_out   (pix_out)
  );

  rghpc_checker checker_u (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pix_in      (pix_in),
    .pix_out     (pix_out),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  // Stall the output side about a third of the time while gaps are on
  always @(negedge clk) begin
    if (rst) begin
      pix_out.ready = 1'b0;
    end else begin
      pix_out.ready = !gaps_on || ($urandom_range(0, 99) >= 33);
    end
  end

  // Abort if nothing moves for too long; a lost or stuck word ends up here
  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one pixel word, with random idle cycles ahead of it, and hold it
  // until the block takes it. Returns right after the accepting edge.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic e);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 33) begin
      pix_in.valid        = 1'b0;
      pix_in.red_in       = 8'($urandom());
      pix_in.green_in     = 8'($urandom());
      pix_in.blue_in      = 8'($urandom());
      pix_in.end_of_image = 1'($urandom());
      @(negedge clk);
    end
    pix_in.valid        = 1'b1;
    pix_in.red_in       = r;
    pix_in.green_in     = g;
    pix_in.blue_in      = b;
    pix_in.end_of_image = e;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  // Drop valid, drain every pending pixel, then let the pipe go quiet
  task automatic settle();
    @(negedge clk);
    pix_in.valid = 1'b0;
    wait (outstanding == 0);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    if (idx == REG_GAIN) cur_gain = val[GAIN_W-1:0];
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Bias channel bytes toward the edges: zero, full scale, tiny values and
  // the byte where the product crosses 255.0 at the current gain.
  function automatic logic [7:0] pick_byte();
    int t;
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2, 3: return 8'($urandom_range(0, 20));
      4: begin
        if (cur_gain == 0) return 8'($urandom());
        t = 65280 / int'(cur_gain) + int'($urandom_range(0, 2)) - 1;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return 8'(t);
      end
      default: return 8'($urandom());
    endcase
  endfunction

  // Per-phase settings; extremes are fixed, other gains drawn at random, other counts three
  function automatic logic [GAIN_W-1:0] phase_gain(input int k);
    case (k)
      0:  return GAIN_RESET;
      1:  return 12'd0;
      2:  return 12'd4095;
      3:  return 12'd1;
      4:  return 12'd255;
      5:  return 12'd257;
      8:  return 12'd2048;
      10: return 12'd4095;
      12: return 12'd512;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [CC_W-1:0] phase_count(input int k);
    case (k)
      1:  return 3'd4;
      2:  return 3'd7;
      3:  return 3'd0;
      5:  return 3'd5;
      6:  return 3'd1;
      8:  return 3'd2;
      9:  return 3'd6;
      10: return 3'd4;
      default: return 3'd3;
    endcase
  endfunction

  initial begin
    cfg_we              = 1'b0;
    cfg_index           = REG_GAIN;
    cfg_data            = '0;
    pix_in.valid        = 1'b0;
    pix_in.red_in       = '0;
    pix_in.green_in     = '0;
    pix_in.blue_in      = '0;
    pix_in.end_of_image = 1'b0;
    pix_out.ready       = 1'b0;

    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Reset settings: unit gain, three channels
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd0,   8'd128, 1'b0);
    send_pixel(8'h55,  8'hAA,  8'h0F,  1'b1);

    // Largest gain: nearly everything overflows and gets normalized to the peak
    settle();
    write_reg(REG_GAIN, 12'd4095);
    write_reg(REG_CHANNEL_COUNT, 12'd7);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd1,   8'd0,   1'b1);
    send_pixel(8'd1,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd15,  8'd16,  8'd3,   1'b0);
    send_pixel(8'd16,  8'd0,   8'd0,   1'b1);

    // Zero gain blanks the pixel
    settle();
    write_reg(REG_GAIN, 12'd0);
    write_reg(REG_CHANNEL_COUNT, 12'd4);
    send_pixel(8'd255, 8'd128, 8'd1, 1'b1);
    send_pixel(8'd7,   8'd255, 8'd0, 1'b0);

    // Fewer than three channels: pixel passes untouched whatever the gain
    settle();
    write_reg(REG_GAIN, 12'd3000);
    write_reg(REG_CHANNEL_COUNT, 12'd0);
    send_pixel(8'd200, 8'd17, 8'd255, 1'b1);
    settle();
    write_reg(REG_CHANNEL_COUNT, 12'd1);
    send_pixel(8'd255, 8'd0, 8'd99, 1'b0);
    settle();
    write_reg(REG_CHANNEL_COUNT, 12'd2);
    send_pixel(8'd1, 8'd254, 8'd128, 1'b1);

    // Right at the 255.0 boundary with gain 257: 254 stays plain, 255 rescales
    settle();
    write_reg(REG_GAIN, 12'd257);
    write_reg(REG_CHANNEL_COUNT, 12'd3);
    send_pixel(8'd254, 8'd100, 8'd0,   1'b0);
    send_pixel(8'd255, 8'd100, 8'd0,   1'b1);
    send_pixel(8'd0,   8'd0,   8'd255, 1'b0);

    // Random phases, each under its own settings; one runs with no gaps
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      write_reg(REG_GAIN, CFG_W'(phase_gain(phase)));
      write_reg(REG_CHANNEL_COUNT, CFG_W'(phase_count(phase)));
      gaps_on = (phase != 7);
      for (n = 0; n < PHASE_WORDS; n++) begin
        send_pixel(pick_byte(), pick_byte(), pick_byte(), ($urandom_range(0, 7) == 0));
      end
    end
    gaps_on = 1'b1;

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> rgb_gain_hue_preserving_clamp.f
hw/rtl/rghpc_pkg.sv
hw/rtl/rghpc_in_if.sv
hw/rtl/rghpc_out_if.sv
hw/rtl/rghpc_div_step.sv
hw/rtl/rgb_gain_hue_preserving_clamp.sv
tb/sv/rghpc_checker.sv
tb/sv/tb_rgb_gain_hue_preserving_clamp.sv
